### hdl/brsr_pkg.sv
// brsr_pkg: shared types, codes and helpers of the block request splitter
// with retry. No dependencies.
`timescale 1ns / 1ps

package brsr_pkg;

  // input operation codes
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_FLUSH = 2'd2;
  localparam logic [1:0] OP_CMPL  = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_FLUSH = 2'd2;
  localparam logic [1:0] KIND_DONE  = 2'd3;

  // finish codes
  localparam logic [1:0] RC_OK      = 2'd0;
  localparam logic [1:0] RC_INVALID = 2'd1;
  localparam logic [1:0] RC_IOERR   = 2'd2;
  localparam logic [1:0] RC_BUSY    = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_PART_OFFSET  = 2'd0;
  localparam logic [1:0] REG_PART_SECTORS = 2'd1;
  localparam logic [1:0] REG_MAX_CHUNK    = 2'd2;
  localparam logic [1:0] REG_FLUSH_SUP    = 2'd3;

  localparam logic [15:0] MAX_CHUNK_RESET = 16'd128;

  // queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [15:0] max_chunk;
    logic        flush_supported;
  } cfg_t;

  // classified item handed from front to back
  typedef struct packed {
    logic [1:0]  op;
    logic        bad;       // read/write refused as invalid
    logic [31:0] abs_lba;   // lba plus partition offset, wrapped
    logic [31:0] count;
    logic [15:0] chunk0;    // size of the first chunk
    logic        ok;
  } q_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] disk_lba;
    logic [15:0] chunk_sectors;
    logic [1:0]  result_code;
  } out_item_t;

  // per-transfer limit, zero treated as one
  function automatic logic [15:0] chunk_limit(input logic [15:0] max_chunk);
    chunk_limit = (max_chunk == 16'd0) ? 16'd1 : max_chunk;
  endfunction

  // smaller of the sectors left and the limit
  function automatic logic [15:0] chunk_min(input logic [31:0] left,
                                            input logic [15:0] lim);
    if (left[31:16] != 16'd0)
      chunk_min = lim;
    else if (left[15:0] < lim)
      chunk_min = left[15:0];
    else
      chunk_min = lim;
  endfunction

endpackage

### hdl/brsr_front.sv
// brsr_front: classifies incoming items (bound check, address offset,
// first chunk size) before they enter the queue. Uses brsr_pkg.
`timescale 1ns / 1ps

module brsr_front (
  input  logic [1:0]        op,
  input  logic [31:0]       lba,
  input  logic [31:0]       count,
  input  logic              status_ok,
  input  logic [31:0]       part_offset,
  input  logic [31:0]       part_sectors,
  input  logic [15:0]       max_chunk,
  output brsr_pkg::q_item_t item
);

  logic [32:0] end_sum;
  logic [15:0] lim;

  // bound check without wrap, address offset with wrap
  assign end_sum = {1'b0, lba} + {1'b0, count};
  assign lim     = brsr_pkg::chunk_limit(max_chunk);

  always_comb begin
    item.op      = op;
    item.bad     = (count == 32'd0) || (end_sum > {1'b0, part_sectors});
    item.abs_lba = lba + part_offset;
    item.count   = count;
    item.chunk0  = brsr_pkg::chunk_min(count, lim);
    item.ok      = status_ok;
  end

endmodule

### hdl/brsr_queue.sv
// brsr_queue: short register queue of classified items between the front
// and the back. Uses brsr_pkg.
`timescale 1ns / 1ps

module brsr_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  brsr_pkg::q_item_t push_item,
  input  logic              pop,
  output brsr_pkg::q_item_t head,
  output logic              empty,
  output logic              full
);

  brsr_pkg::q_item_t                  mem_r [brsr_pkg::QDEPTH];
  logic [brsr_pkg::QPTR_W-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [brsr_pkg::QPTR_W-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [brsr_pkg::QCNT_W-1:0]        cnt_r, cnt_nxt;

  localparam logic [brsr_pkg::QPTR_W-1:0] PTR_LAST = brsr_pkg::QPTR_W'(brsr_pkg::QDEPTH - 1);
  localparam logic [brsr_pkg::QCNT_W-1:0] CNT_FULL = brsr_pkg::QCNT_W'(brsr_pkg::QDEPTH);

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == CNT_FULL);
  assign head  = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push)
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    if (pop)
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    if (push && !pop)
      cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push)
      cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push)
      mem_r[wr_ptr_r] <= push_item;
  end

endmodule

### hdl/brsr_back.sv
// brsr_back: executes classified items against the request state, issues
// chunks, retries and finishes; holds the output register. Uses brsr_pkg.
`timescale 1ns / 1ps

module brsr_back #(
  parameter int RETRY_LIMIT = 3
) (
  input  logic                clk,
  input  logic                rst_n,
  input  brsr_pkg::q_item_t   head,
  input  logic                empty,
  output logic                pop,
  input  brsr_pkg::cfg_t      cfg,
  output logic                out_valid,
  input  logic                out_ready,
  output brsr_pkg::out_item_t out_item
);

  localparam logic [1:0] LIMIT = 2'(RETRY_LIMIT);

  logic        busy_r, busy_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic [31:0] cur_lba_r, cur_lba_nxt;   // base plus sectors done
  logic [31:0] rem_r, rem_nxt;           // sectors not yet completed
  logic [15:0] chunk_r, chunk_nxt;
  logic [1:0]  att_r, att_nxt;
  logic        out_valid_r;
  brsr_pkg::out_item_t out_r, res;
  logic        emit;
  logic        go;

  logic [15:0] lim;
  logic [31:0] rem_after;
  logic [31:0] lba_after;

  assign lim       = brsr_pkg::chunk_limit(cfg.max_chunk);
  assign rem_after = rem_r - {16'd0, chunk_r};
  assign lba_after = cur_lba_r + {16'd0, chunk_r};

  // one item per cycle while the output register is free or draining
  assign go  = !empty && (!out_valid_r || out_ready);
  assign pop = go;

  // item execution
  always_comb begin
    busy_nxt    = busy_r;
    kind_nxt    = kind_r;
    cur_lba_nxt = cur_lba_r;
    rem_nxt     = rem_r;
    chunk_nxt   = chunk_r;
    att_nxt     = att_r;
    emit        = 1'b0;
    res         = '{kind: brsr_pkg::KIND_DONE, disk_lba: 32'd0,
                    chunk_sectors: 16'd0, result_code: brsr_pkg::RC_OK};
    if (head.op == brsr_pkg::OP_CMPL) begin
      if (busy_r) begin
        emit = 1'b1;
        if (head.ok && (kind_r == brsr_pkg::KIND_FLUSH || rem_after == 32'd0)) begin
          busy_nxt = 1'b0;
          att_nxt  = 2'd0;
        end else if (head.ok) begin
          // next chunk
          rem_nxt     = rem_after;
          cur_lba_nxt = lba_after;
          chunk_nxt   = brsr_pkg::chunk_min(rem_after, lim);
          att_nxt     = 2'd1;
          res.kind          = kind_r;
          res.disk_lba      = lba_after;
          res.chunk_sectors = brsr_pkg::chunk_min(rem_after, lim);
        end else if (att_r < LIMIT) begin
          // retry the same chunk or flush
          att_nxt           = att_r + 2'd1;
          res.kind          = kind_r;
          res.disk_lba      = cur_lba_r;
          res.chunk_sectors = chunk_r;
        end else begin
          busy_nxt        = 1'b0;
          att_nxt         = 2'd0;
          res.result_code = brsr_pkg::RC_IOERR;
        end
      end
    end else begin
      emit = 1'b1;
      if (busy_r) begin
        res.result_code = brsr_pkg::RC_BUSY;
      end else if (head.op == brsr_pkg::OP_FLUSH) begin
        if (cfg.flush_supported) begin
          busy_nxt    = 1'b1;
          kind_nxt    = brsr_pkg::KIND_FLUSH;
          cur_lba_nxt = 32'd0;
          rem_nxt     = 32'd0;
          chunk_nxt   = 16'd0;
          att_nxt     = 2'd1;
          res.kind    = brsr_pkg::KIND_FLUSH;
        end
      end else if (head.bad) begin
        res.result_code = brsr_pkg::RC_INVALID;
      end else begin
        // start of a read or write
        busy_nxt          = 1'b1;
        kind_nxt          = head.op;
        cur_lba_nxt       = head.abs_lba;
        rem_nxt           = head.count;
        chunk_nxt         = head.chunk0;
        att_nxt           = 2'd1;
        res.kind          = head.op;
        res.disk_lba      = head.abs_lba;
        res.chunk_sectors = head.chunk0;
      end
    end
  end

  // request state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      att_r  <= 2'd0;
    end else if (go) begin
      busy_r <= busy_nxt;
      att_r  <= att_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      kind_r    <= kind_nxt;
      cur_lba_r <= cur_lba_nxt;
      rem_r     <= rem_nxt;
      chunk_r   <= chunk_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n)
      out_valid_r <= 1'b0;
    else if (go)
      out_valid_r <= emit;
    else if (out_ready)
      out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (go && emit)
      out_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // checks
  a_busy_att: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> att_r != 2'd0)
    else $error("request in flight with no attempt counted");

  a_att_lim: assert property (@(posedge clk) disable iff (!rst_n)
    att_r <= LIMIT)
    else $error("attempt count above retry limit");

  a_chunk_fit: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && kind_r != brsr_pkg::KIND_FLUSH) |->
      (chunk_r != 16'd0 && {16'd0, chunk_r} <= rem_r))
    else $error("chunk empty or larger than sectors left");

  a_no_pop_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !pop)
    else $error("queue popped while result is stalled");

endmodule

### hdl/block_request_split_retry_unit.sv
// block_request_split_retry_unit: top level of the block request splitter
// with retry; holds configuration, ties front, queue and back together.
// Uses brsr_pkg, brsr_front, brsr_queue, brsr_back.
//
//   channel | dir | handshake          | payload
//   in_     | in  | in_tvalid/tready   | tuser: op; tdata: lba, count, status_ok
//   out_    | out | out_tvalid/tready  | tuser: kind; tdata: disk_lba, chunk_sectors,
//           |     |                    |        result_code
//   cfg_    | in  | cfg_we             | cfg_index, cfg_wdata
//
// An item enters the queue when it is accepted; from the queue head the single
// back execution stage registers its result in the output register: one item
// per cycle sustained while out_tready does not stall the output register.
// Synchronous active-low reset clears queue, request state and output valid.
// in_tready drops only when the two-entry queue is full; out_tready stalls
// hold the output register and stop the back stage.
`timescale 1ns / 1ps

module block_request_split_retry_unit #(
  parameter int RETRY_LIMIT = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // op
  input  logic [71:0] in_tdata,   // lba[31:0], count[63:32], status_ok[64], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [1:0]  out_tuser,  // kind
  output logic [55:0] out_tdata,  // disk_lba[31:0], chunk_sectors[47:32],
                                  // result_code[49:48], zero pad
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  logic [31:0] part_offset_r;
  logic [31:0] part_sectors_r;
  logic [15:0] max_chunk_r;
  logic        flush_sup_r;

  brsr_pkg::q_item_t   cls_item, head;
  brsr_pkg::out_item_t res;
  brsr_pkg::cfg_t      cfg;
  logic                q_empty, q_full, q_pop, q_push;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      part_offset_r  <= 32'd0;
      part_sectors_r <= 32'd0;
      max_chunk_r    <= brsr_pkg::MAX_CHUNK_RESET;
      flush_sup_r    <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        brsr_pkg::REG_PART_OFFSET:  part_offset_r  <= cfg_wdata;
        brsr_pkg::REG_PART_SECTORS: part_sectors_r <= cfg_wdata;
        brsr_pkg::REG_MAX_CHUNK:    max_chunk_r    <= cfg_wdata[15:0];
        brsr_pkg::REG_FLUSH_SUP:    flush_sup_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign cfg = '{max_chunk: max_chunk_r, flush_supported: flush_sup_r};

  // front: classify
  brsr_front u_front (
    .op           (in_tuser),
    .lba          (in_tdata[31:0]),
    .count        (in_tdata[63:32]),
    .status_ok    (in_tdata[64]),
    .part_offset  (part_offset_r),
    .part_sectors (part_sectors_r),
    .max_chunk    (max_chunk_r),
    .item         (cls_item)
  );

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  // queue between front and back
  brsr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (cls_item),
    .pop       (q_pop),
    .head      (head),
    .empty     (q_empty),
    .full      (q_full)
  );

  // back: execute
  brsr_back #(
    .RETRY_LIMIT (RETRY_LIMIT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .empty     (q_empty),
    .pop       (q_pop),
    .cfg       (cfg),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_item  (res)
  );

  assign out_tuser = res.kind;
  assign out_tdata = {6'd0, res.result_code, res.chunk_sectors, res.disk_lba};

endmodule

### dv/block_request_split_retry_unit_tb.sv
// block_request_split_retry_unit_tb: self-checking bench for the request splitter with retry;
// a scoreboard class mirrors partition checks, chunking and retries, plain tasks drive the ports.
// Depends on brsr_pkg and block_request_split_retry_unit.
`timescale 1ns / 1ps

module block_request_split_retry_unit_tb;

  localparam int RETRY_LIMIT    = 3;
  localparam int CYCLE_LIMIT    = 500000;
  localparam int PHASES         = 6;
  localparam int PHASE_RESULTS  = 250;
  localparam int CMPL_ABORT     = 16;   // completions per request before forcing failures
  localparam int SETTLE_CYCLES  = 8;

  // mirror of the splitter: partition view, request in flight, expected output items
  class split_retry_scoreboard;
    logic [31:0] offset;
    logic [31:0] part_size;
    logic [15:0] chunk_max;
    logic        flush_ok;
    logic        busy;
    logic [1:0]  cur_kind;
    logic [31:0] start_lba;
    logic [31:0] total;
    logic [31:0] done;
    logic [15:0] chunk;
    int          tries;
    brsr_pkg::out_item_t pending_cmds[$];
    int          mismatches;
    int          n_issue, n_ok, n_invalid, n_ioerr, n_busy, n_dropped, n_checked;

    function new();
      offset    = '0;
      part_size = '0;
      chunk_max = brsr_pkg::MAX_CHUNK_RESET;
      flush_ok  = 1'b1;
      busy      = 1'b0;
      cur_kind  = brsr_pkg::KIND_READ;
      start_lba = '0;
      total     = '0;
      done      = '0;
      chunk     = '0;
      tries     = 0;
      mismatches = 0;
      n_issue = 0; n_ok = 0; n_invalid = 0; n_ioerr = 0; n_busy = 0; n_dropped = 0;
      n_checked = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        brsr_pkg::REG_PART_OFFSET:  offset    = val;
        brsr_pkg::REG_PART_SECTORS: part_size = val;
        brsr_pkg::REG_MAX_CHUNK:    chunk_max = val[15:0];
        brsr_pkg::REG_FLUSH_SUP:    flush_ok  = val[0];
        default: ;
      endcase
    endfunction

    // next chunk: smaller of what is left and the transfer limit (zero limit acts as one)
    function brsr_pkg::out_item_t issue_next_chunk();
      logic [31:0] left;
      logic [31:0] lim;
      brsr_pkg::out_item_t it;
      left  = total - done;
      lim   = (chunk_max == 16'd0) ? 32'd1 : {16'd0, chunk_max};
      chunk = (left < lim) ? left[15:0] : lim[15:0];
      tries = 1;
      it.kind          = cur_kind;
      it.disk_lba      = start_lba + done;
      it.chunk_sectors = chunk;
      it.result_code   = brsr_pkg::RC_OK;
      return it;
    endfunction

    function void end_request();
      busy  = 1'b0;
      tries = 0;
    endfunction

    // apply one accepted item; returns 1 when it produces an output item
    function bit note_input(logic [1:0] op, logic [31:0] lba, logic [31:0] cnt, logic ok);
      brsr_pkg::out_item_t it;
      it.kind          = brsr_pkg::KIND_DONE;
      it.disk_lba      = '0;
      it.chunk_sectors = '0;
      it.result_code   = brsr_pkg::RC_OK;
      if (op == brsr_pkg::OP_CMPL) begin
        if (!busy) begin
          n_dropped++;
          return 1'b0;
        end
        if (ok && cur_kind == brsr_pkg::KIND_FLUSH) begin
          end_request();
        end else if (ok) begin
          done = done + {16'd0, chunk};
          if (done >= total) end_request();
          else it = issue_next_chunk();
        end else if (tries < RETRY_LIMIT) begin
          tries++;
          it.kind = cur_kind;
          if (cur_kind != brsr_pkg::KIND_FLUSH) begin
            it.disk_lba      = start_lba + done;
            it.chunk_sectors = chunk;
          end
        end else begin
          end_request();
          it.result_code = brsr_pkg::RC_IOERR;
        end
      end else if (busy) begin
        it.result_code = brsr_pkg::RC_BUSY;
      end else if (op == brsr_pkg::OP_FLUSH) begin
        if (flush_ok) begin
          busy      = 1'b1;
          cur_kind  = brsr_pkg::KIND_FLUSH;
          start_lba = '0;
          total     = '0;
          done      = '0;
          chunk     = '0;
          tries     = 1;
          it.kind   = brsr_pkg::KIND_FLUSH;
        end
      end else if (cnt == 32'd0 || {32'd0, lba} + {32'd0, cnt} > {32'd0, part_size}) begin
        it.result_code = brsr_pkg::RC_INVALID;
      end else begin
        busy      = 1'b1;
        cur_kind  = (op == brsr_pkg::OP_READ) ? brsr_pkg::KIND_READ : brsr_pkg::KIND_WRITE;
        start_lba = lba + offset;
        total     = cnt;
        done      = '0;
        it        = issue_next_chunk();
      end
      // tally what the run covers
      if (it.kind != brsr_pkg::KIND_DONE) n_issue++;
      else case (it.result_code)
        brsr_pkg::RC_OK:      n_ok++;
        brsr_pkg::RC_INVALID: n_invalid++;
        brsr_pkg::RC_IOERR:   n_ioerr++;
        default:              n_busy++;
      endcase
      pending_cmds.push_back(it);
      return 1'b1;
    endfunction

    task report_mismatch(string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      mismatches++;
    endtask

    task check_result(brsr_pkg::out_item_t got);
      brsr_pkg::out_item_t want;
      if (pending_cmds.size() == 0) begin
        report_mismatch($sformatf("unexpected item kind %0d lba %h sectors %0d code %0d",
                                  got.kind, got.disk_lba, got.chunk_sectors, got.result_code));
        return;
      end
      want = pending_cmds.pop_front();
      n_checked++;
      if (got.kind != want.kind)
        report_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
      if (got.disk_lba != want.disk_lba)
        report_mismatch($sformatf("disk_lba %h, want %h", got.disk_lba, want.disk_lba));
      if (got.chunk_sectors != want.chunk_sectors)
        report_mismatch($sformatf("chunk_sectors %0d, want %0d",
                                  got.chunk_sectors, want.chunk_sectors));
      if (got.result_code != want.result_code)
        report_mismatch($sformatf("result_code %0d, want %0d",
                                  got.result_code, want.result_code));
    endtask
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [1:0]  in_tuser   = '0;   // op
  logic [71:0] in_tdata   = '0;   // lba[31:0], count[63:32], status_ok[64], zero pad
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [1:0]  out_tuser;         // kind
  logic [55:0] out_tdata;         // disk_lba[31:0], chunk_sectors[47:32], result_code[49:48]
  logic        cfg_we     = 1'b0;
  logic [1:0]  cfg_index  = '0;
  logic [31:0] cfg_wdata  = '0;

  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  int          cycles      = 0;
  int          result_items = 0;
  int          sent_items   = 0;
  int          cmpl_in_req  = 0;

  split_retry_scoreboard sb = new();

  block_request_split_retry_unit #(
    .RETRY_LIMIT(RETRY_LIMIT)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #6 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("cycle limit hit with %0d items outstanding", sb.pending_cmds.size());
      $display("simulation failed");
      $finish;
    end
  end

  // output side: check accepted items, stall at random
  always @(posedge clk) begin : out_watch
    brsr_pkg::out_item_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.kind          = out_tuser;
      got.disk_lba      = out_tdata[31:0];
      got.chunk_sectors = out_tdata[47:32];
      got.result_code   = out_tdata[49:48];
      sb.check_result(got);
    end
    out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // present one item, hold it until accepted, then update the mirror
  task automatic send_item(logic [1:0] op, logic [31:0] lba, logic [31:0] cnt, logic ok);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {7'd0, ok, cnt, lba};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent_items++;
    if (sb.note_input(op, lba, cnt, ok)) result_items++;
  endtask

  // end any request with failing completions, then wait until the block is quiet
  task automatic settle();
    while (sb.busy) send_item(brsr_pkg::OP_CMPL, $urandom, $urandom, 1'b0);
    in_tvalid <= 1'b0;
    while (sb.pending_cmds.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic configure(logic [31:0] offs, logic [31:0] ps, logic [15:0] mc, logic fs);
    settle();
    write_reg(brsr_pkg::REG_PART_OFFSET, offs);
    write_reg(brsr_pkg::REG_PART_SECTORS, ps);
    write_reg(brsr_pkg::REG_MAX_CHUNK, {16'd0, mc});
    write_reg(brsr_pkg::REG_FLUSH_SUP, {31'd0, fs});
    cfg_we <= 1'b0;
  endtask

  task automatic directed_checks();
    // reset settings: empty partition, flush present
    send_item(brsr_pkg::OP_READ, 32'd0, 32'd1, 1'b0);          // out of range
    send_item(brsr_pkg::OP_CMPL, 32'd0, 32'd0, 1'b1);          // completion while idle, dropped
    send_item(brsr_pkg::OP_FLUSH, 32'd0, 32'd0, 1'b0);
    send_item(brsr_pkg::OP_WRITE, 32'd0, 32'd1, 1'b0);         // refused while busy
    send_item(brsr_pkg::OP_CMPL, '1, '1, 1'b0);
    send_item(brsr_pkg::OP_CMPL, '1, '1, 1'b0);
    send_item(brsr_pkg::OP_CMPL, '1, '1, 1'b0);                // retries used up, io error
    // wrapping offset, zero chunk limit, no flush command
    configure(32'hFFFF_FFF0, 32'hFFFF_FFFF, 16'd0, 1'b0);
    send_item(brsr_pkg::OP_FLUSH, '1, '1, 1'b1);               // finishes at once
    send_item(brsr_pkg::OP_WRITE, 32'h20, 32'd3, 1'b0);
    send_item(brsr_pkg::OP_CMPL, 32'd0, 32'd0, 1'b1);
    send_item(brsr_pkg::OP_CMPL, 32'd0, 32'd0, 1'b1);
    send_item(brsr_pkg::OP_CMPL, 32'd0, 32'd0, 1'b1);
    send_item(brsr_pkg::OP_READ, 32'hFFFF_FFFF, 32'd1, 1'b0);  // one past the partition end
    send_item(brsr_pkg::OP_READ, 32'hFFFF_FFFE, 32'd1, 1'b0);  // last sector, address wraps
    send_item(brsr_pkg::OP_CMPL, 32'd0, 32'd0, 1'b0);
    send_item(brsr_pkg::OP_CMPL, 32'd0, 32'd0, 1'b1);
    send_item(brsr_pkg::OP_READ, 32'd5, 32'd0, 1'b0);          // zero count
    // widest chunks, whole partition
    configure(32'd0, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
    send_item(brsr_pkg::OP_READ, 32'd0, 32'hFFFF_FFFF, 1'b1);
    send_item(brsr_pkg::OP_CMPL, '1, '1, 1'b1);
    send_item(brsr_pkg::OP_CMPL, '1, '1, 1'b0);
    send_item(brsr_pkg::OP_CMPL, '1, '1, 1'b0);
    send_item(brsr_pkg::OP_CMPL, '1, '1, 1'b0);
    send_item(brsr_pkg::OP_FLUSH, 32'd0, 32'd0, 1'b0);
    send_item(brsr_pkg::OP_CMPL, 32'd0, 32'd0, 1'b1);
    send_item(brsr_pkg::OP_CMPL, 32'd0, 32'd0, 1'b0);          // idle again, dropped
  endtask

  // one random item, mostly well-formed request/completion traffic
  task automatic random_step();
    logic [1:0]  op;
    logic [31:0] lba;
    logic [31:0] cnt;
    logic        ok;
    logic [31:0] lim;
    logic [31:0] cap;
    logic [31:0] ps;
    int          r;
    r   = $urandom_range(0, 99);
    op  = brsr_pkg::OP_CMPL;
    lba = $urandom;
    cnt = $urandom;
    ok  = 1'($urandom_range(0, 1));
    ps  = sb.part_size;
    if (sb.busy) begin
      if (r < 90) ok = (cmpl_in_req < CMPL_ABORT) && ($urandom_range(0, 99) < 85);
      else op = 2'($urandom_range(0, 2));
    end else if (r < 70 && ps != 32'd0) begin
      // in-range read or write
      op  = ($urandom_range(0, 1) != 0) ? brsr_pkg::OP_WRITE : brsr_pkg::OP_READ;
      lim = (sb.chunk_max == 16'd0) ? 32'd1 : {16'd0, sb.chunk_max};
      cap = ($urandom_range(0, 3) != 0 && lim * 4 < ps) ? lim * 4 : ps;
      cnt = $urandom_range(1, cap);
      lba = ($urandom_range(0, 9) == 0) ? ps - cnt : $urandom_range(0, ps - cnt);
    end else if (r < 82) begin
      op = brsr_pkg::OP_FLUSH;
    end else if (r < 94) begin
      // refused as invalid
      op = ($urandom_range(0, 1) != 0) ? brsr_pkg::OP_WRITE : brsr_pkg::OP_READ;
      if ($urandom_range(0, 2) == 0) cnt = 32'd0;
      else begin
        if (cnt == 32'd0) cnt = 32'd1;
        if ({32'd0, lba} + {32'd0, cnt} <= {32'd0, ps}) lba = ps - cnt + 32'd1;
      end
    end
    send_item(op, lba, cnt, ok);
    if (!sb.busy) cmpl_in_req = 0;
    else if (op == brsr_pkg::OP_CMPL) cmpl_in_req++;
  endtask

  initial begin
    logic [31:0] offs;
    logic [31:0] ps;
    logic [15:0] mc;
    int          target;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    directed_checks();

    for (int ph = 0; ph < PHASES; ph++) begin
      case ($urandom_range(0, 2))
        0:       offs = 32'd0;
        1:       offs = 32'hFFFF_FFFF;
        default: offs = $urandom;
      endcase
      case ($urandom_range(0, 4))
        0:       ps = 32'hFFFF_FFFF;
        1, 2:    ps = $urandom_range(1, 2000);
        3:       ps = $urandom;
        default: ps = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom_range(1, 64);
      endcase
      case ($urandom_range(0, 4))
        0:       mc = 16'd0;
        1:       mc = 16'd1;
        2:       mc = 16'hFFFF;
        3:       mc = 16'($urandom_range(2, 16));
        default: mc = 16'($urandom_range(1, 65535));
      endcase
      configure(offs, ps, mc, $urandom_range(0, 9) != 0);
      // receiver idles first, then sender, then neither
      case (ph / 2)
        0:       begin tx_idle_pct <= 23; rx_idle_pct <= 84; end
        1:       begin tx_idle_pct <= 84; rx_idle_pct <= 23; end
        default: begin tx_idle_pct <= 0;  rx_idle_pct <= 0;  end
      endcase
      cmpl_in_req = 0;
      target = result_items + PHASE_RESULTS;
      while (result_items < target) random_step();
    end

    settle();
    $display("sent %0d items: %0d chunk/flush issues, finishes ok %0d invalid %0d io error %0d",
             sent_items, sb.n_issue, sb.n_ok, sb.n_invalid, sb.n_ioerr);
    $display("busy refusals %0d, idle completions dropped %0d, %0d output items checked",
             sb.n_busy, sb.n_dropped, sb.n_checked);
    if (sb.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
